@@ rtl/itpa_pkg.sv @@
// ----------------------------------------------------------------------------
// itpa_pkg
// Shared types, constants and helpers of the padded integer formatter.
// ----------------------------------------------------------------------------
package itpa_pkg;

  localparam int DEF_VALUE_BITS  = 64;
  localparam int DEF_DIGIT_DEPTH = 22;
  localparam int DEF_MAX_WIDTH   = 64;

  localparam int MAX_PRECISION = 61;
  localparam int MAX_RESULTS   = 64;

  // input transaction layout, lowest bit first
  localparam int IN_BITS  = 88;
  localparam int OUT_BITS = 8;

  localparam logic [1:0] BASE_OCT = 2'd0;
  localparam logic [1:0] BASE_DEC = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  localparam logic [1:0] SIGN_NONE  = 2'd0;
  localparam logic [1:0] SIGN_MINUS = 2'd1;
  localparam logic [1:0] SIGN_SPACE = 2'd2;
  localparam logic [1:0] SIGN_PLUS  = 2'd3;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_X_UP  = 8'h58;
  localparam logic [7:0] CHAR_X_LO  = 8'h78;
  localparam logic [7:0] CHAR_A_UP  = 8'h41;
  localparam logic [7:0] CHAR_A_LO  = 8'h61;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_SETUP,
    ST_PRE,
    ST_SIGN,
    ST_PFX0,
    ST_PFXX,
    ST_ZPAD,
    ST_LEAD,
    ST_DIG,
    ST_POST
  } state_t;

  typedef enum logic [2:0] {
    CH_SPACE,
    CH_SIGN,
    CH_ZERO,
    CH_X,
    CH_DIGIT
  } char_sel_t;

  typedef enum logic [1:0] {
    CNT_NONE,
    CNT_PAD,
    CNT_LEAD,
    CNT_DIG
  } cnt_sel_t;

  typedef struct packed {
    logic      load;
    logic      conv;
    logic      setup;
    logic      emit;
    char_sel_t sel;
    cnt_sel_t  dec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic conv_last;
    logic last_now;
    logic pre_on;
    logic sign_on;
    logic pfx0_on;
    logic pfxx_on;
    logic zpad_on;
    logic lead_on;
    logic post_on;
    logic pad_one;
    logic lead_one;
    logic dig_one;
  } ctrl_stat_t;

  // digit to ascii, 0-9 then a-f or A-F
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base_char;
    base_char = upper ? CHAR_A_UP : CHAR_A_LO;
    if (d < 4'd10) begin
      digit_char = CHAR_ZERO + {4'd0, d};
    end else begin
      digit_char = base_char + {4'd0, d} - 8'd10;
    end
  endfunction

endpackage

@@ rtl/itpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// itpa_ctrl
// Sequencer: conversion, length setup and the character phases of one field.
// ----------------------------------------------------------------------------
module itpa_ctrl
  import itpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '{load: 1'b0, conv: 1'b0, setup: 1'b0, emit: 1'b0,
                   sel: CH_SPACE, dec: CNT_NONE};
    in_ready   = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv = 1'b1;
        if (stat.conv_last) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_PRE;
      end
      ST_PRE: begin
        cmd.sel = CH_SPACE;
        cmd.dec = CNT_PAD;
        if (!stat.pre_on) begin
          state_next = ST_SIGN;
        end else if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.last_now) state_next = ST_IDLE;
          else if (stat.pad_one) state_next = ST_SIGN;
        end
      end
      ST_SIGN: begin
        cmd.sel = CH_SIGN;
        if (!stat.sign_on) begin
          state_next = ST_PFX0;
        end else if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = stat.last_now ? ST_IDLE : ST_PFX0;
        end
      end
      ST_PFX0: begin
        cmd.sel = CH_ZERO;
        if (!stat.pfx0_on) begin
          state_next = ST_PFXX;
        end else if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = stat.last_now ? ST_IDLE : ST_PFXX;
        end
      end
      ST_PFXX: begin
        cmd.sel = CH_X;
        if (!stat.pfxx_on) begin
          state_next = ST_ZPAD;
        end else if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = stat.last_now ? ST_IDLE : ST_ZPAD;
        end
      end
      ST_ZPAD: begin
        cmd.sel = CH_ZERO;
        cmd.dec = CNT_PAD;
        if (!stat.zpad_on) begin
          state_next = ST_LEAD;
        end else if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.last_now) state_next = ST_IDLE;
          else if (stat.pad_one) state_next = ST_LEAD;
        end
      end
      ST_LEAD: begin
        cmd.sel = CH_ZERO;
        cmd.dec = CNT_LEAD;
        if (!stat.lead_on) begin
          state_next = ST_DIG;
        end else if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.last_now) state_next = ST_IDLE;
          else if (stat.lead_one) state_next = ST_DIG;
        end
      end
      ST_DIG: begin
        cmd.sel = CH_DIGIT;
        cmd.dec = CNT_DIG;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.last_now) state_next = ST_IDLE;
          else if (stat.dig_one) state_next = ST_POST;
        end
      end
      ST_POST: begin
        cmd.sel = CH_SPACE;
        cmd.dec = CNT_PAD;
        if (!stat.post_on) begin
          state_next = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.last_now || stat.pad_one) state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/itpa_datapath.sv @@
// ----------------------------------------------------------------------------
// itpa_datapath
// Request registers, digit conversion, run counters and the output register.
// ----------------------------------------------------------------------------
module itpa_datapath
  import itpa_pkg::*;
#(
  parameter int VALUE_BITS  = DEF_VALUE_BITS,
  parameter int DIGIT_DEPTH = DEF_DIGIT_DEPTH,
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [IN_BITS-1:0]  in_data,
  input  ctrl_cmd_t           cmd,
  output ctrl_stat_t          stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OUT_BITS-1:0] out_data,
  output logic                out_last
);

  // value register rounded up to an even width, two bits per decimal step
  localparam int SB    = ((VALUE_BITS + 1) / 2) * 2;
  localparam int STEPS = SB / 2;
  localparam int SW    = $clog2(STEPS);
  localparam int CW    = $clog2(DIGIT_DEPTH + 1);
  localparam int IW    = $clog2(DIGIT_DEPTH);
  localparam logic [7:0] MAX_W8 = 8'(MAX_WIDTH);

  // request fields
  logic [1:0] base;
  logic [6:0] width_sat;
  logic [5:0] prec;
  logic [1:0] sign_mode;
  logic       left;
  logic       zpad;
  logic       upper;
  logic       alt;

  logic [SB-1:0] val;
  logic [3:0]    digits [DIGIT_DEPTH];
  logic [CW-1:0] ndig;
  logic [SW-1:0] step;

  logic [6:0]    pad_left;
  logic [5:0]    lead_left;
  logic [CW-1:0] dig_left;
  logic [6:0]    len;
  logic [6:0]    cnt;

  logic [6:0] in_width;
  logic [5:0] in_prec;
  logic       is_dec;
  logic       is_hex;
  logic       is_oct;

  logic [3:0]    dd [DIGIT_DEPTH];
  logic [IW-1:0] top_idx;
  logic          grow;
  logic [SB-1:0] val_shift;
  logic [3:0]    small_digit;

  logic [5:0]    lead_val;
  logic [1:0]    pre_len;
  logic [6:0]    body;
  logic [6:0]    pad_val;
  logic [6:0]    total;
  logic [6:0]    len_val;
  logic [CW-1:0] dig_m1;
  logic [7:0]    sign_char;
  logic [7:0]    char_val;

  assign in_width = ({1'b0, in_data[72:66]} > MAX_W8) ? MAX_W8[6:0] : in_data[72:66];
  assign in_prec  = (in_data[78:73] > 6'(MAX_PRECISION)) ? 6'(MAX_PRECISION)
                                                         : in_data[78:73];

  assign is_dec = (base == BASE_DEC);
  assign is_oct = (base == BASE_OCT);
  assign is_hex = !is_dec && !is_oct;

  // two double-dabble steps per cycle, top bits of val shift in
  always_comb begin
    dd = digits;
    for (int s = 0; s < 2; s++) begin
      for (int k = 0; k < DIGIT_DEPTH; k++) begin
        if (dd[k] >= 4'd5) dd[k] = dd[k] + 4'd3;
      end
      for (int k = DIGIT_DEPTH - 1; k > 0; k--) begin
        dd[k] = {dd[k][2:0], dd[k-1][3]};
      end
      dd[0] = {dd[0][2:0], val[SB-1-s]};
    end
  end

  // value at most quadruples per cycle, so the digit count grows by one at most
  assign top_idx = (ndig < CW'(DIGIT_DEPTH)) ? ndig[IW-1:0] : '0;
  assign grow    = (ndig < CW'(DIGIT_DEPTH)) && (dd[top_idx] != 4'd0);

  assign val_shift   = is_hex ? (val >> 4) : (val >> 3);
  assign small_digit = is_hex ? val[3:0] : {1'b0, val[2:0]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val       <= SB'(in_data[VALUE_BITS-1:0]);
      base      <= in_data[65:64];
      width_sat <= in_width;
      prec      <= in_prec;
      sign_mode <= in_data[80:79];
      left      <= in_data[81];
      zpad      <= in_data[82];
      upper     <= in_data[83];
      alt       <= in_data[84];
      step      <= '0;
      if (in_data[65:64] == BASE_DEC) begin
        ndig <= CW'(1);
        for (int k = 0; k < DIGIT_DEPTH; k++) digits[k] <= 4'd0;
      end else begin
        ndig <= '0;
      end
    end else if (cmd.conv) begin
      if (is_dec) begin
        val    <= val << 2;
        digits <= dd;
        step   <= step + 1'b1;
        if (grow) ndig <= ndig + 1'b1;
      end else begin
        val                  <= val_shift;
        digits[ndig[IW-1:0]] <= small_digit;
        ndig                 <= ndig + 1'b1;
      end
    end
  end

  // field lengths
  assign lead_val = (prec > 6'(ndig)) ? (prec - 6'(ndig)) : 6'd0;
  assign pre_len  = alt ? (is_hex ? 2'd2 : (is_oct ? 2'd1 : 2'd0)) : 2'd0;
  assign body     = 7'(sign_mode != SIGN_NONE) + 7'(pre_len) + 7'(lead_val) + 7'(ndig);
  assign pad_val  = (width_sat > body) ? (width_sat - body) : 7'd0;
  assign total    = body + pad_val;
  assign len_val  = (total > 7'(MAX_RESULTS)) ? 7'(MAX_RESULTS) : total;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      pad_left  <= pad_val;
      lead_left <= lead_val;
      dig_left  <= ndig;
      len       <= len_val;
      cnt       <= '0;
    end else if (cmd.emit) begin
      cnt <= cnt + 1'b1;
      unique case (cmd.dec)
        CNT_NONE: ;
        CNT_PAD:  pad_left  <= pad_left - 1'b1;
        CNT_LEAD: lead_left <= lead_left - 1'b1;
        CNT_DIG:  dig_left  <= dig_left - 1'b1;
        default:  ;
      endcase
    end
  end

  assign dig_m1 = dig_left - 1'b1;

  always_comb begin
    unique case (sign_mode)
      SIGN_MINUS: sign_char = CHAR_MINUS;
      SIGN_PLUS:  sign_char = CHAR_PLUS;
      default:    sign_char = CHAR_SPACE;
    endcase
  end

  always_comb begin
    unique case (cmd.sel)
      CH_SPACE: char_val = CHAR_SPACE;
      CH_SIGN:  char_val = sign_char;
      CH_ZERO:  char_val = CHAR_ZERO;
      CH_X:     char_val = upper ? CHAR_X_UP : CHAR_X_LO;
      CH_DIGIT: char_val = digit_char(digits[dig_m1[IW-1:0]], upper);
      default:  char_val = CHAR_SPACE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= char_val;
      out_last <= stat.last_now;
    end
  end

  always_comb begin
    stat.out_free  = !out_valid || out_ready;
    stat.conv_last = is_dec ? (step == SW'(STEPS - 1))
                            : ((val_shift == '0) || (ndig == CW'(DIGIT_DEPTH - 1)));
    stat.last_now  = (cnt == len - 1'b1);
    stat.pre_on    = !left && !zpad && (pad_left != 7'd0);
    stat.zpad_on   = !left && zpad && (pad_left != 7'd0);
    stat.post_on   = left && (pad_left != 7'd0);
    stat.sign_on   = (sign_mode != SIGN_NONE);
    stat.pfx0_on   = alt && !is_dec;
    stat.pfxx_on   = alt && is_hex;
    stat.lead_on   = (lead_left != 6'd0);
    stat.pad_one   = (pad_left == 7'd1);
    stat.lead_one  = (lead_left == 6'd1);
    stat.dig_one   = (dig_left == CW'(1));
  end

endmodule

@@ rtl/integer_to_padded_ascii.sv @@
// Steps: the request is accepted, then converted (two double-dabble steps a cycle for
// decimal, one digit a cycle for octal and hex, up to DIGIT_DEPTH digits), then set
// up, then one character a cycle unless m_tready stalls the output, up to 64 in all;
// an empty field section still passes through its own state. One item at a time:
// after the final character is loaded the block is idle and takes the next request.
// Reset: rst clears the sequencer and the output valid; the digit store is not cleared.
// ----------------------------------------------------------------------------
// integer_to_padded_ascii
// Formats an unsigned integer as a padded octal, decimal or hex ascii field.
// ----------------------------------------------------------------------------
module integer_to_padded_ascii
  import itpa_pkg::*;
#(
  parameter int VALUE_BITS  = DEF_VALUE_BITS,
  parameter int DIGIT_DEPTH = DEF_DIGIT_DEPTH,
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // magnitude[63:0], base_sel[65:64], field_width[72:66], min_digits[78:73],
  // sign_mode[80:79], align_left[81], pad_zero[82], upper_hex[83],
  // alt_prefix[84], zero fill[87:85]
  input  logic [IN_BITS-1:0]  s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // out_char[7:0]
  output logic [OUT_BITS-1:0] m_tdata,
  output logic                m_tlast
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  itpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  itpa_datapath #(
    .VALUE_BITS  (VALUE_BITS),
    .DIGIT_DEPTH (DIGIT_DEPTH),
    .MAX_WIDTH   (MAX_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

@@ rtl/itpa_checker.sv @@
// ----------------------------------------------------------------------------
// itpa_checker
// Port-level checks of the formatter, bound to the top level.
// ----------------------------------------------------------------------------
module itpa_checker
  import itpa_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OUT_BITS-1:0] m_tdata,
  input logic                m_tlast
);

  // a stalled character holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

  // an accepted request keeps the block busy
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // a pending non-final character means the field is still in progress
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("idle in the middle of a field");

  // when idle, a pending character can only be the final one, and it is plain ascii
  assert property (@(posedge clk) disable iff (rst)
    s_tready && m_tvalid |-> m_tlast && !m_tdata[7])
    else $error("idle with a non-final or non-ascii character pending");

endmodule

bind integer_to_padded_ascii itpa_checker u_checker (.*);
